// ----- sv/hsc_pkg.sv -----
// Shared types and constants for the Hamming single-error codec.
// No dependencies; imported by the core, the top level and the checker.
package hsc_pkg;

  localparam int DATA_W           = 63;  // codeword port width
  localparam int MSG_W            = 57;  // message port width
  localparam int POS_W            = 6;   // error position port width
  localparam int R_W              = 3;   // redundancy register width
  localparam int DEF_PARITY_BITS  = 6;   // default upper bound on r
  localparam logic [R_W-1:0] R_RESET = 3'd3;
  localparam logic [R_W-1:0] R_MIN   = 3'd2;

  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } hsc_func_t;

  typedef struct packed {
    logic [DATA_W-1:0] codeword;
    logic [MSG_W-1:0]  message;
    logic              error_detected;
    logic [POS_W-1:0]  error_position;
  } hsc_result_t;

endpackage

// ----- sv/hamming_single_error_codec.sv -----
// Channel  Handshake       Payload
// cfg      valid / ready   cfg_data (r, parity bit count)
// in       valid / stall   in_func, in_data_in
// out      valid / stall   out_codeword, out_message, out_error_detected,
//                          out_error_position
//
// One request per cycle sustained while out is not stalled; a request passes
// the input register, then parity/syndrome XOR trees into the result register.
// rst_n is synchronous; it empties both stages and sets r to 3.
// An out stall holds the result; a new request is still taken while the input
// stage is empty or can drain into the result register in the same cycle.
// Depends on hsc_pkg and hsc_core.
module hamming_single_error_codec import hsc_pkg::*; #(
  parameter int MAX_PARITY_BITS = DEF_PARITY_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [R_W-1:0]    cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [DATA_W-1:0] in_data_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_codeword,
  output logic [MSG_W-1:0]  out_message,
  output logic              out_error_detected,
  output logic [POS_W-1:0]  out_error_position
);

  localparam logic [R_W-1:0] R_MAX = R_W'(MAX_PARITY_BITS);

  logic [R_W-1:0]    r_r;
  logic [R_W-1:0]    r_eff;
  logic              s1_valid_r, s1_valid_nxt;
  hsc_func_t         s1_func_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  hsc_result_t       res_r, res_nxt;
  logic              out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= R_RESET;
    end else if (cfg_valid) begin
      r_r <= cfg_data;
    end
  end

  always_comb begin
    r_eff = r_r;
    if (r_r < R_MIN) r_eff = R_MIN;
    if (r_r > R_MAX) r_eff = R_MAX;
  end

  // result register free, or being emptied this cycle
  assign out_take      = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !out_take;
  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = out_take ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_func_r <= hsc_func_t'(in_func);
      s1_data_r <= in_data_in;
    end
    if (out_take && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  hsc_core #(
    .MAX_PARITY_BITS(MAX_PARITY_BITS)
  ) u_core (
    .func    (s1_func_r),
    .r_eff   (r_eff),
    .data_in (s1_data_r),
    .result  (res_nxt)
  );

  assign out_valid          = out_valid_r;
  assign out_codeword       = res_r.codeword;
  assign out_message        = res_r.message;
  assign out_error_detected = res_r.error_detected;
  assign out_error_position = res_r.error_position;

endmodule

// ----- sv/hsc_core.sv -----
// Combinational encode / syndrome-decode datapath for Hamming(2^r-1, 2^r-r-1).
// Depends on hsc_pkg.
module hsc_core import hsc_pkg::*; #(
  parameter int MAX_PARITY_BITS = DEF_PARITY_BITS
) (
  input  hsc_func_t          func,
  input  logic [R_W-1:0]     r_eff,
  input  logic [DATA_W-1:0]  data_in,
  output hsc_result_t        result
);

  localparam int CW_N  = (1 << MAX_PARITY_BITS) - 1;
  localparam int MSG_N = CW_N - MAX_PARITY_BITS;

  logic [CW_N-1:0]            cw_mask;
  logic [CW_N-1:0]            enc_data;
  logic [CW_N-1:0]            parity_bits;
  logic [CW_N-1:0]            dec_in;
  logic [CW_N-1:0]            src;
  logic [CW_N-1:0]            flip;
  logic [CW_N-1:0]            cw_fin;
  logic [MSG_N-1:0]           msg_out;
  logic [MAX_PARITY_BITS-1:0] syn;

  // Data bit k lands on the k-th non power-of-two position, counting up,
  // independent of r; positions beyond 2^r-1 are masked off.
  for (genvar i = 0; i < CW_N; i++) begin : g_pos
    localparam int P   = i + 1;
    localparam int LVL = $clog2(P + 1);
    assign cw_mask[i] = (r_eff >= R_W'(LVL));
    if ((P & (P - 1)) == 0) begin : g_par
      assign enc_data[i]    = 1'b0;
      assign parity_bits[i] = syn[LVL-1];
    end else begin : g_dat
      localparam int K = P - 1 - LVL;
      assign enc_data[i]    = data_in[K] & cw_mask[i];
      assign parity_bits[i] = 1'b0;
      assign msg_out[K]     = cw_fin[i];
    end
    assign flip[i] = (syn == MAX_PARITY_BITS'(P));
  end

  assign dec_in = data_in[CW_N-1:0] & cw_mask;
  assign src    = (func == FUNC_DECODE) ? dec_in : enc_data;

  // syndrome bit j: parity over positions with index bit j set
  always_comb begin
    syn = '0;
    for (int i = 0; i < CW_N; i++) begin
      for (int j = 0; j < MAX_PARITY_BITS; j++) begin
        if ((((i + 1) >> j) & 1) != 0) syn[j] = syn[j] ^ src[i];
      end
    end
  end

  assign cw_fin = (func == FUNC_DECODE) ? (dec_in ^ flip) : (enc_data | parity_bits);

  always_comb begin
    result.codeword       = DATA_W'(cw_fin);
    result.message        = MSG_W'(msg_out);
    result.error_detected = (func == FUNC_DECODE) && (syn != '0);
    result.error_position = (func == FUNC_DECODE) ? POS_W'(syn) : '0;
  end

endmodule

// ----- sv/hsc_checker.sv -----
// Port-level assertions for hamming_single_error_codec, bound to the top level.
// Depends on hsc_pkg.
module hsc_checker import hsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_func,
  input logic [DATA_W-1:0] in_data_in,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_codeword,
  input logic [MSG_W-1:0]  out_message,
  input logic              out_error_detected,
  input logic [POS_W-1:0]  out_error_position
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_data_in))
    else $error("request changed while stalled");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_codeword) && $stable(out_message)
      && $stable(out_error_position))
    else $error("result changed under stall");

  a_no_err_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_detected |-> out_error_position == '0)
    else $error("error position set without error flag");

  a_err_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_detected |-> out_error_position != '0)
    else $error("error flag with zero position");

endmodule

bind hamming_single_error_codec hsc_checker u_hsc_checker (.*);

// ----- tb/hsc_tb_pkg.sv -----
// Result predictor and scoreboard for the Hamming single-error codec bench.
// Depends on hsc_pkg; imported by tb_top.
`timescale 1ns / 100ps
package hsc_tb_pkg;
  import hsc_pkg::*;

  class hamming_checker;
    hsc_result_t pending_results[$];
    int          mismatches;
    int          encode_count;
    int          decode_count;
    int          corrected_count;

    function new();
      mismatches      = 0;
      encode_count    = 0;
      decode_count    = 0;
      corrected_count = 0;
    endfunction

    // r as the block uses it: clamped into 2..MAX_PARITY_BITS
    static function int parity_count(logic [R_W-1:0] r_reg);
      int r;
      r = r_reg;
      if (r < 2) r = 2;
      if (r > DEF_PARITY_BITS) r = DEF_PARITY_BITS;
      return r;
    endfunction

    static function hsc_result_t hamming_result(logic [R_W-1:0] r_reg, hsc_func_t fn,
                                                logic [DATA_W-1:0] d);
      hsc_result_t      res;
      int               r;
      int               n;
      int               k;
      logic [POS_W-1:0] syn;
      logic [DATA_W-1:0] cw;
      logic [MSG_W-1:0] msg;
      r   = parity_count(r_reg);
      n   = (1 << r) - 1;
      cw  = '0;
      msg = '0;
      syn = '0;
      if (fn == FUNC_ENCODE) begin
        // message MSB lands on the highest non-parity position
        k = n - r;
        for (int p = n; p >= 1; p--) begin
          if ((p & (p - 1)) == 0) continue;
          k--;
          msg[k] = d[k];
          if (d[k]) begin
            cw[p-1] = 1'b1;
            syn ^= POS_W'(p);
          end
        end
        for (int j = 0; j < r; j++) begin
          if (syn[j]) cw[(1 << j) - 1] = 1'b1;
        end
        syn = '0;
      end else begin
        for (int p = 1; p <= n; p++) begin
          cw[p-1] = d[p-1];
          if (d[p-1]) syn ^= POS_W'(p);
        end
        if (syn != 0) cw[syn-1] = ~cw[syn-1];
        for (int p = n; p >= 1; p--) begin
          if ((p & (p - 1)) == 0) continue;
          msg = {msg[MSG_W-2:0], cw[p-1]};
        end
      end
      res.codeword       = cw;
      res.message        = msg;
      res.error_detected = (syn != 0);
      res.error_position = syn;
      return res;
    endfunction

    function void note_request(logic [R_W-1:0] r_reg, hsc_func_t fn,
                               logic [DATA_W-1:0] d);
      hsc_result_t res;
      res = hamming_result(r_reg, fn, d);
      if (fn == FUNC_ENCODE) encode_count++;
      else decode_count++;
      if (res.error_detected) corrected_count++;
      pending_results.push_back(res);
    endfunction

    function void check_result(hsc_result_t act);
      hsc_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, none pending: codeword %h", $time, act.codeword);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (act.codeword !== exp.codeword) begin
        $display("%0t: codeword expected %h actual %h", $time, exp.codeword, act.codeword);
        mismatches++;
      end
      if (act.message !== exp.message) begin
        $display("%0t: message expected %h actual %h", $time, exp.message, act.message);
        mismatches++;
      end
      if (act.error_detected !== exp.error_detected) begin
        $display("%0t: error_detected expected %b actual %b", $time,
                 exp.error_detected, act.error_detected);
        mismatches++;
      end
      if (act.error_position !== exp.error_position) begin
        $display("%0t: error_position expected %0d actual %0d", $time,
                 exp.error_position, act.error_position);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level bench for hamming_single_error_codec: random and directed
// encode/decode traffic with stalls, checked through hsc_tb_pkg's scoreboard.
// Depends on hsc_pkg, hsc_tb_pkg and the codec RTL.
`timescale 1ns / 100ps
module tb_top;
  import hsc_pkg::*;
  import hsc_tb_pkg::*;

  localparam int PHASE_ITEMS = 220;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [R_W-1:0]    cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_func = 1'b0;
  logic [DATA_W-1:0] in_data_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_codeword;
  logic [MSG_W-1:0]  out_message;
  logic              out_error_detected;
  logic [POS_W-1:0]  out_error_position;

  hamming_checker    sb;
  logic [R_W-1:0]    r_cur = R_RESET;
  int                idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_on = 1'b0;
  int                idle_tab[4] = '{0, 45, 0, 28};
  int                stall_tab[4] = '{0, 0, 45, 28};
  logic [R_W-1:0]    r_plan[8] = '{3'd2, 3'd7, 3'd0, 3'd4, 3'd5, 3'd1, 3'd6, 3'd3};

  hamming_single_error_codec u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_data_in         (in_data_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_codeword       (out_codeword),
    .out_message        (out_message),
    .out_error_detected (out_error_detected),
    .out_error_position (out_error_position)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check what was taken at this edge, then pick the next stall
  always @(posedge clk) begin
    hsc_result_t act;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        act.codeword       = out_codeword;
        act.message        = out_message;
        act.error_detected = out_error_detected;
        act.error_position = out_error_position;
        sb.check_result(act);
      end
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(hsc_func_t fn, logic [DATA_W-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= fn;
    in_data_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r_cur, fn, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_r(logic [R_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    r_cur = v;
  endtask

  task automatic hold_receiver(int cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return DATA_W'({$urandom(), $urandom()});
  endfunction

  // random messages to encode, codewords with zero or one flipped bit to decode, plus raw noise
  task automatic send_random();
    int                n;
    int                roll;
    hsc_result_t       enc;
    logic [DATA_W-1:0] cw;
    logic [DATA_W-1:0] cw_mask;
    n       = (1 << hamming_checker::parity_count(r_cur)) - 1;
    cw_mask = DATA_W'((64'd1 << n) - 64'd1);
    roll    = $urandom_range(99);
    if (roll < 40) begin
      send_request(FUNC_ENCODE, rand_word());
    end else if (roll < 85) begin
      enc = hamming_checker::hamming_result(r_cur, FUNC_ENCODE, rand_word());
      cw  = enc.codeword;
      if ($urandom_range(3) != 0) cw[$urandom_range(n - 1)] ^= 1'b1;
      if ($urandom_range(3) == 0) cw |= rand_word() & ~cw_mask;
      send_request(FUNC_DECODE, cw);
    end else begin
      send_request(FUNC_DECODE, rand_word());
    end
  endtask

  initial begin
    logic [DATA_W-1:0] base;
    hsc_result_t       enc;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // r = 3 out of reset: extremes, excess bits, every single-bit error
    send_request(FUNC_ENCODE, '0);
    send_request(FUNC_ENCODE, '1);
    send_request(FUNC_DECODE, '0);
    send_request(FUNC_DECODE, '1);
    enc  = hamming_checker::hamming_result(r_cur, FUNC_ENCODE, DATA_W'(4'b1011));
    base = enc.codeword;
    for (int p = 1; p <= 7; p++) send_request(FUNC_DECODE, base ^ (DATA_W'(1) << (p - 1)));
    drain();

    // widest code
    write_r(3'd6);
    send_request(FUNC_ENCODE, '0);
    send_request(FUNC_ENCODE, '1);
    send_request(FUNC_DECODE, '1);
    send_request(FUNC_DECODE, DATA_W'(1) << 62);
    send_request(FUNC_DECODE, DATA_W'(1));
    enc  = hamming_checker::hamming_result(r_cur, FUNC_ENCODE, rand_word());
    base = enc.codeword;
    send_request(FUNC_DECODE, base ^ (DATA_W'(1) << 31));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_r(r_plan[ph]);
      idle_pct  = idle_tab[ph % 4];
      stall_pct = stall_tab[ph % 4];
      // long receiver hold while the sender keeps pushing, to back up the pipe
      if (ph == 4) begin
        fork
          hold_receiver(300);
        join_none
      end
      repeat (PHASE_ITEMS) send_random();
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain();
    repeat (10) @(posedge clk);

    if (sb.pending() != 0) sb.mismatches++;
    $display("Covered %0d encode and %0d decode requests, %0d with a corrected bit,",
             sb.encode_count, sb.decode_count, sb.corrected_count);
    $display("over all eight r register values and four idle/stall mixes.");
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", sb.pending());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
